[src/ppad_pkg.sv]
`timescale 1ns / 1ps

package ppad_pkg;

    // Field widths
    localparam int IN_W   = 16;
    localparam int DIFF_W = 17;
    localparam int MID_W  = 17;
    localparam int ANG_W  = 19;
    localparam int DIST_W = 25;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 80;

    // CORDIC datapath: 36-bit x/y covers 2^16 pre-scale, sqrt(2) and gain
    localparam int CORDIC_STAGES = 20;
    localparam int CW            = 36;
    localparam int ZW            = 32;
    localparam int KW            = 27;
    localparam int PROD_W        = ZW + KW;

    // Binary angle constants, full turn = 2^32
    localparam logic [ZW-1:0] Z_ZERO     = 32'h0000_0000;
    localparam logic [ZW-1:0] Z_QUARTER  = 32'h4000_0000;
    localparam logic [ZW-1:0] Z_HALF     = 32'h8000_0000;
    localparam logic [ZW-1:0] Z_3QUARTER = 32'hC000_0000;

    // Turn to output unit scale factors
    localparam logic [KW-1:0] TURN_DEG_Q8 = 27'd92160;
    localparam logic [KW-1:0] TWO_PI_Q24  = 27'd105414357;
    localparam logic [ANG_W-1:0] FULL_DEG = 19'd92160;
    localparam logic [ANG_W-1:0] FULL_RAD = 19'd411775;
    localparam logic [ANG_W-1:0] ANG_MAX  = 19'd411774;

    localparam logic [ZW-1:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // Square root: one result bit per stage
    localparam int SQRT_BITS = 25;
    localparam int SQW       = 51;

    // Latencies from the difference register to the aligned outputs
    localparam int CORDIC_LAT = CORDIC_STAGES + 3;
    localparam int SQRT_LAT   = SQRT_BITS + 4;
    localparam int PIPE_LAT   = (CORDIC_LAT > SQRT_LAT) ? CORDIC_LAT : SQRT_LAT;

    // Result item, angle in the lowest bits
    typedef struct packed {
        logic                     points_coincide;
        logic signed [MID_W-1:0]  midpoint_y;
        logic signed [MID_W-1:0]  midpoint_x;
        logic [DIST_W-1:0]        distance;
        logic [ANG_W-1:0]         angle;
    } result_t;

endpackage

[src/ppad_cordic.sv]
`timescale 1ns / 1ps

module ppad_cordic import ppad_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     angle_in_radians,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    output logic [ANG_W-1:0]         angle
);

    localparam int PAD = PIPE_LAT - CORDIC_LAT;

    logic signed [CW-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES+1];
    logic [ZW-1:0]        z_reg [CORDIC_STAGES+1];
    logic                 axis_reg [CORDIC_STAGES+1];

    logic signed [DIFF_W-1:0] px, py;
    logic [ZW-1:0]            z_init;
    logic                     axis;

    // Pre-rotation into the right half plane, axis directions settled here
    always_comb begin
        px   = dx[DIFF_W-1] ? -dx : dx;
        py   = dx[DIFF_W-1] ? -dy : dy;
        axis = (dx == '0) || (dy == '0);
        if (dy == '0) begin
            z_init = (dx > 0) ? Z_ZERO : Z_HALF;
        end else if (dx == '0) begin
            z_init = (dy > 0) ? Z_QUARTER : Z_3QUARTER;
        end else begin
            z_init = dx[DIFF_W-1] ? Z_HALF : Z_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CW'(px) <<< 16;
            y_reg[0]    <= CW'(py) <<< 16;
            z_reg[0]    <= z_init;
            axis_reg[0] <= axis;
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (en) begin
                axis_reg[i+1] <= axis_reg[i];
                if (!y_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= axis_reg[i] ? z_reg[i] : z_reg[i] + ATAN_TURNS[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= axis_reg[i] ? z_reg[i] : z_reg[i] - ATAN_TURNS[i];
                end
            end
        end
    end

    // Scale the binary angle to degrees or radians
    logic [PROD_W-1:0] prod_reg;
    logic              rad_reg;
    logic [PROD_W-1:0] rounded;
    logic [ANG_W-1:0]  ang_raw;
    logic [ANG_W-1:0]  ang_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(z_reg[CORDIC_STAGES])
                        * PROD_W'(angle_in_radians ? TWO_PI_Q24 : TURN_DEG_Q8);
            rad_reg  <= angle_in_radians;
        end
    end

    always_comb begin
        rounded = prod_reg + (rad_reg ? (PROD_W'(1) << 39) : (PROD_W'(1) << 31));
        ang_raw = rad_reg ? rounded[58:40] : rounded[50:32];
    end

    // Full-turn rounding folds back to zero
    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= (ang_raw >= (rad_reg ? FULL_RAD : FULL_DEG)) ? '0 : ang_raw;
        end
    end

    // Align with the square-root path
    if (PAD > 0) begin : g_pad
        logic [ANG_W-1:0] dly_reg [PAD];
        always_ff @(posedge aclk) begin
            if (en) begin
                dly_reg[0] <= ang_reg;
            end
        end
        for (genvar k = 1; k < PAD; k++) begin : g_dly
            always_ff @(posedge aclk) begin
                if (en) begin
                    dly_reg[k] <= dly_reg[k-1];
                end
            end
        end
        assign angle = dly_reg[PAD-1];
    end else begin : g_nopad
        assign angle = ang_reg;
    end

endmodule

[src/ppad_isqrt.sv]
`timescale 1ns / 1ps

module ppad_isqrt import ppad_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    output logic [DIST_W-1:0]        distance
);

    localparam int PAD = PIPE_LAT - SQRT_LAT;

    logic signed [DIFF_W-1:0] ndx, ndy;
    logic [IN_W-1:0]          ax_reg, ay_reg;
    logic [2*IN_W-1:0]        sqx_reg, sqy_reg;
    logic [2*IN_W:0]          sq_sum;
    logic [SQW-1:0]           rem_reg [SQRT_BITS+1];
    logic [SQW-1:0]           res_reg [SQRT_BITS+1];
    logic [DIST_W-1:0]        dist_reg;

    // Magnitudes of the differences
    always_comb begin
        ndx    = -dx;
        ndy    = -dy;
        sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg     <= dx[DIFF_W-1] ? ndx[IN_W-1:0] : dx[IN_W-1:0];
            ay_reg     <= dy[DIFF_W-1] ? ndy[IN_W-1:0] : dy[IN_W-1:0];
            sqx_reg    <= (2*IN_W)'(ax_reg) * (2*IN_W)'(ax_reg);
            sqy_reg    <= (2*IN_W)'(ay_reg) * (2*IN_W)'(ay_reg);
            rem_reg[0] <= SQW'(sq_sum) << 16;
            res_reg[0] <= '0;
        end
    end

    // Restoring square root, one result bit per stage
    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_iter
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQRT_BITS - 1 - j));
        logic [SQW-1:0] trial;
        assign trial = res_reg[j] + BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[j] >= trial) begin
                    rem_reg[j+1] <= rem_reg[j] - trial;
                    res_reg[j+1] <= (res_reg[j] >> 1) + BIT;
                end else begin
                    rem_reg[j+1] <= rem_reg[j];
                    res_reg[j+1] <= res_reg[j] >> 1;
                end
            end
        end
    end

    // Round to nearest: up when the remainder exceeds the root
    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= res_reg[SQRT_BITS][DIST_W-1:0]
                        + DIST_W'(rem_reg[SQRT_BITS] > res_reg[SQRT_BITS]);
        end
    end

    // Align with the angle path
    if (PAD > 0) begin : g_pad
        logic [DIST_W-1:0] dly_reg [PAD];
        always_ff @(posedge aclk) begin
            if (en) begin
                dly_reg[0] <= dist_reg;
            end
        end
        for (genvar k = 1; k < PAD; k++) begin : g_dly
            always_ff @(posedge aclk) begin
                if (en) begin
                    dly_reg[k] <= dly_reg[k-1];
                end
            end
        end
        assign distance = dly_reg[PAD-1];
    end else begin : g_nopad
        assign distance = dist_reg;
    end

endmodule

[src/point_pair_angle_distance.sv]
`timescale 1ns / 1ps

// Point-pair angle and distance. Each input beat carries an origin and a
// destination point; each output beat gives the direction (CORDIC vectoring,
// degrees Q9.8 or radians Q3.16 as set by the one-bit config register), the
// rounded distance Q.8 (pipelined bit-per-stage square root), twice the
// midpoint and a coincidence flag. One pair is taken every cycle unless input
// is held off. A beat passes the difference register, the longer arithmetic
// path (with the default 20 CORDIC stages, the 25-stage square root) and the
// output register. A two-entry output buffer lets the pipeline keep running
// while a result waits; input is held off only when both entries are full.
// Write the config register only while no beat is in flight.

module point_pair_angle_distance import ppad_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,      // angle_in_radians
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] origin_x, [31:16] origin_y, [47:32] dest_x, [63:48] dest_y
    input  logic [S_TDATA_W-1:0] s_tdata,
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [18:0] angle, [43:19] distance, [60:44] midpoint_x,
    // [77:61] midpoint_y, [78] points_coincide, [79] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic angle_in_radians_reg;
    logic en;

    // Config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_in_radians_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            angle_in_radians_reg <= cfg_data;
        end
    end

    // Input fields
    logic signed [IN_W-1:0] ox, oy, tx, ty;

    always_comb begin
        ox = s_tdata[15:0];
        oy = s_tdata[31:16];
        tx = s_tdata[47:32];
        ty = s_tdata[63:48];
    end

    // First stage: differences, sums, coincidence
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic                     vld_reg  [PIPE_LAT+1];
    logic signed [MID_W-1:0]  midx_reg [PIPE_LAT+1];
    logic signed [MID_W-1:0]  midy_reg [PIPE_LAT+1];
    logic                     same_reg [PIPE_LAT+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg      <= DIFF_W'(tx) - DIFF_W'(ox);
            dy_reg      <= DIFF_W'(oy) - DIFF_W'(ty);
            midx_reg[0] <= MID_W'(ox) + MID_W'(tx);
            midy_reg[0] <= MID_W'(oy) + MID_W'(ty);
            same_reg[0] <= (ox == tx) && (oy == ty);
        end
    end

    // Side-band delay matching the arithmetic pipelines
    for (genvar i = 0; i < PIPE_LAT; i++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                midx_reg[i+1] <= midx_reg[i];
                midy_reg[i+1] <= midy_reg[i];
                same_reg[i+1] <= same_reg[i];
            end
        end
    end

    logic [ANG_W-1:0]  cordic_angle;
    logic [DIST_W-1:0] root_dist;

    ppad_cordic u_cordic (
        .aclk             (aclk),
        .en               (en),
        .angle_in_radians (angle_in_radians_reg),
        .dx               (dx_reg),
        .dy               (dy_reg),
        .angle            (cordic_angle)
    );

    ppad_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .dx       (dx_reg),
        .dy       (dy_reg),
        .distance (root_dist)
    );

    // Assemble the finished result
    result_t pipe_res;

    always_comb begin
        pipe_res.points_coincide = same_reg[PIPE_LAT];
        pipe_res.midpoint_y      = midy_reg[PIPE_LAT];
        pipe_res.midpoint_x      = midx_reg[PIPE_LAT];
        pipe_res.distance        = root_dist;
        pipe_res.angle           = same_reg[PIPE_LAT] ? '0 : cordic_angle;
    end

    // Output register plus skid entry
    result_t out_reg, skid_reg;
    logic    out_vld_reg, skid_vld_reg;
    logic    push, pop;

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign push     = en && vld_reg[PIPE_LAT];
    assign pop      = out_vld_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (skid_vld_reg) begin
                if (pop) begin
                    skid_vld_reg <= 1'b0;
                end
            end else if (push) begin
                if (!out_vld_reg || pop) begin
                    out_vld_reg <= 1'b1;
                end else begin
                    skid_vld_reg <= 1'b1;
                end
            end else if (pop) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!out_vld_reg || pop) begin
                out_reg <= pipe_res;
            end else begin
                skid_reg <= pipe_res;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_reg};

`ifndef SYNTH
    // The skid entry is only ever occupied behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry valid while output register empty");

    // The skid entry fills only when the output was stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_tready))
        else $error("skid entry filled without an output stall");

    // Coincident points give zero angle and zero distance
    a_coincide: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_reg.points_coincide)
            |-> (out_reg.angle == '0 && out_reg.distance == '0))
        else $error("coincident points with nonzero angle or distance");

    // Angle never reaches a full turn
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (out_reg.angle <= ANG_MAX))
        else $error("angle beyond full turn");
`endif

endmodule
